// ===== hdl/mexp_pkg.sv =====
package mexp_pkg;

	localparam int W = 32;
	localparam int BIT_W = $clog2(W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

	localparam logic [W-1:0] MODULUS_RST  = W'(2);
	localparam logic [W-1:0] EXPONENT_RST = W'(1);

	typedef enum logic [2:0] {
		STEP_IDLE   = 3'd0,
		STEP_REDUCE = 3'd1,
		STEP_SQUARE = 3'd2,
		STEP_TEST   = 3'd3,
		STEP_MUL    = 3'd4,
		STEP_LOOP   = 3'd5,
		STEP_OUT    = 3'd6
	} step_t;

	typedef enum logic [1:0] {
		SRC_ONE_MSG,
		SRC_ACC_ACC,
		SRC_ACC_BASE
	} src_t;

	typedef enum logic {
		DST_BASE,
		DST_ACC
	} dst_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_WAIT_IN,
		J_EBIT_CLR,
		J_LOOP,
		J_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic  mul;
		src_t  src;
		dst_t  dst;
		jmp_t  jmp;
		step_t target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t u;
		u = '{mul: 1'b0, src: SRC_ONE_MSG, dst: DST_ACC, jmp: J_WAIT_IN, target: STEP_IDLE};
		case (pc)
			STEP_IDLE: begin
				u = '{mul: 1'b0, src: SRC_ONE_MSG, dst: DST_ACC, jmp: J_WAIT_IN,
					target: STEP_OUT};
			end
			STEP_REDUCE: begin
				u = '{mul: 1'b1, src: SRC_ONE_MSG, dst: DST_BASE, jmp: J_NEXT,
					target: STEP_SQUARE};
			end
			STEP_SQUARE: begin
				u = '{mul: 1'b1, src: SRC_ACC_ACC, dst: DST_ACC, jmp: J_NEXT,
					target: STEP_TEST};
			end
			STEP_TEST: begin
				u = '{mul: 1'b0, src: SRC_ACC_BASE, dst: DST_ACC, jmp: J_EBIT_CLR,
					target: STEP_LOOP};
			end
			STEP_MUL: begin
				u = '{mul: 1'b1, src: SRC_ACC_BASE, dst: DST_ACC, jmp: J_NEXT,
					target: STEP_LOOP};
			end
			STEP_LOOP: begin
				u = '{mul: 1'b0, src: SRC_ACC_ACC, dst: DST_ACC, jmp: J_LOOP,
					target: STEP_SQUARE};
			end
			STEP_OUT: begin
				u = '{mul: 1'b0, src: SRC_ACC_ACC, dst: DST_ACC, jmp: J_WAIT_OUT,
					target: STEP_IDLE};
			end
			default: begin
				u = '{mul: 1'b0, src: SRC_ONE_MSG, dst: DST_ACC, jmp: J_WAIT_IN,
					target: STEP_IDLE};
			end
		endcase
		return u;
	endfunction

	// (x + y) mod m for x, y below m
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

endpackage

// ===== hdl/modular_exponentiation_unit.sv =====
// Computes message ** exponent mod modulus for each 32-bit input beat, with modulus and
// exponent written beforehand over the cfg port (index 0 modulus, 1 exponent; other indexes
// are ignored). A modulus below 2 gives 0. Control is a seven-step microprogram driving one
// shift-add modular multiplier that handles one multiplier bit per cycle. A new item is accepted
// once the previous result has been moved into the output register.
module modular_exponentiation_unit
	import mexp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [W-1:0]         s_axis_tdata,  // message
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [W-1:0]         m_axis_tdata   // result
);

	step_t            pc_q, pc_d;
	logic             mrun_q, mrun_d;
	logic [BIT_W-1:0] mcnt_q, mcnt_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [W-1:0]     mod_q, exp_q;
	logic [W-1:0]     msg_q, msg_d;
	logic [W-1:0]     base_q, base_d;
	logic [W-1:0]     acc_q, acc_d;
	logic [W-1:0]     mr_q, mr_d;
	logic [W-1:0]     ma_q, ma_d;
	logic [W-1:0]     mb_q, mb_d;
	logic [W-1:0]     res_q, res_d;
	logic             out_valid_q, out_valid_d;
	ucode_t           uc;
	logic             small_mod;
	logic             in_fire;
	logic [W-1:0]     dbl, mstep;

	assign uc            = ucode_rom(pc_q);
	assign small_mod     = (mod_q < W'(2));
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (pc_q == STEP_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	// one bit of the shift-add product
	assign dbl   = add_mod(mr_q, mr_q, mod_q);
	assign mstep = mb_q[mcnt_q] ? add_mod(dbl, ma_q, mod_q) : dbl;

	always_comb begin
		pc_d        = pc_q;
		mrun_d      = mrun_q;
		mcnt_d      = mcnt_q;
		bit_d       = bit_q;
		msg_d       = msg_q;
		base_d      = base_q;
		acc_d       = acc_q;
		mr_d        = mr_q;
		ma_d        = ma_q;
		mb_d        = mb_q;
		res_d       = res_q;
		out_valid_d = out_valid_q;

		if (m_axis_tvalid && m_axis_tready) begin
			out_valid_d = 1'b0;
		end

		if (uc.mul) begin
			if (!mrun_q) begin
				mrun_d = 1'b1;
				mcnt_d = BIT_W'(W - 1);
				mr_d   = '0;
				case (uc.src)
					SRC_ONE_MSG: begin
						ma_d = W'(1);
						mb_d = msg_q;
					end
					SRC_ACC_ACC: begin
						ma_d = acc_q;
						mb_d = acc_q;
					end
					SRC_ACC_BASE: begin
						ma_d = base_q;
						mb_d = acc_q;
					end
					default: begin
						ma_d = acc_q;
						mb_d = acc_q;
					end
				endcase
			end else begin
				mr_d = mstep;
				if (mcnt_q == '0) begin
					mrun_d = 1'b0;
					if (uc.dst == DST_BASE) begin
						base_d = mstep;
					end else begin
						acc_d = mstep;
					end
					pc_d = step_t'(pc_q + 3'd1);
				end else begin
					mcnt_d = mcnt_q - BIT_W'(1);
				end
			end
		end else begin
			case (uc.jmp)
				J_WAIT_IN: begin
					if (in_fire) begin
						msg_d = s_axis_tdata;
						bit_d = BIT_W'(W - 1);
						if (small_mod) begin
							acc_d = '0;
							pc_d  = uc.target;
						end else begin
							acc_d = W'(1);
							pc_d  = step_t'(pc_q + 3'd1);
						end
					end
				end
				J_EBIT_CLR: begin
					pc_d = exp_q[bit_q] ? step_t'(pc_q + 3'd1) : uc.target;
				end
				J_LOOP: begin
					if (bit_q == '0) begin
						pc_d = step_t'(pc_q + 3'd1);
					end else begin
						bit_d = bit_q - BIT_W'(1);
						pc_d  = uc.target;
					end
				end
				J_WAIT_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						res_d       = acc_q;
						out_valid_d = 1'b1;
						pc_d        = uc.target;
					end
				end
				default: begin
					pc_d = step_t'(pc_q + 3'd1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			mrun_q      <= 1'b0;
			out_valid_q <= 1'b0;
			mod_q       <= MODULUS_RST;
			exp_q       <= EXPONENT_RST;
		end else begin
			pc_q        <= pc_d;
			mrun_q      <= mrun_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS:  mod_q <= cfg_data;
					REG_EXPONENT: exp_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mcnt_q <= mcnt_d;
		bit_q  <= bit_d;
		msg_q  <= msg_d;
		base_q <= base_d;
		acc_q  <= acc_d;
		mr_q   <= mr_d;
		ma_q   <= ma_d;
		mb_q   <= mb_d;
		res_q  <= res_d;
	end

	a_mul_in_mul_step: assert property (@(posedge clk) disable iff (!arst_n)
		mrun_q |-> uc.mul)
		else $error("multiplier running outside a multiply step");

	a_result_from_out_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(pc_q) == STEP_OUT)
		else $error("result presented outside the output step");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> pc_q != STEP_IDLE)
		else $error("sequencer stayed idle after accepting a beat");

endmodule

// ===== tb/sv/power_mod_checker.sv =====
module power_mod_checker
	import mexp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [W-1:0]         s_axis_tdata,  // message
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [W-1:0]         m_axis_tdata,  // result
	output int                   mismatch_count,
	output int                   residues_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [W-1:0] message;
		logic [W-1:0] residue;
	} residue_t;

	residue_t     expected_residues[$];
	logic [W-1:0] modulus_reg;
	logic [W-1:0] exponent_reg;

	// square-and-multiply, products held exactly in double width
	function automatic logic [W-1:0] power_mod(input logic [W-1:0] msg,
		input logic [W-1:0] m, input logic [W-1:0] e);
		logic [2*W-1:0] m_wide;
		logic [2*W-1:0] base;
		logic [2*W-1:0] acc;
		if (m < 2) begin
			return '0;
		end
		m_wide = {{W{1'b0}}, m};
		base = {{W{1'b0}}, msg % m};
		acc = (2*W)'(1);
		for (int i = W - 1; i >= 0; i--) begin
			acc = (acc * acc) % m_wide;
			if (e[i]) begin
				acc = (acc * base) % m_wide;
			end
		end
		return acc[W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		residue_t want;
		if (!arst_n) begin
			modulus_reg <= MODULUS_RST;
			exponent_reg <= EXPONENT_RST;
			expected_residues.delete();
			mismatch_count <= 0;
			residues_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS: begin
						modulus_reg <= cfg_data;
					end
					REG_EXPONENT: begin
						exponent_reg <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want.message = s_axis_tdata;
				want.residue = power_mod(s_axis_tdata, modulus_reg, exponent_reg);
				expected_residues.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_residues.size() == 0) begin
					$display("%0t: result %h with no message outstanding", $time, m_axis_tdata);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_residues.pop_front();
					if (want.residue !== m_axis_tdata) begin
						$display("%0t: message %h: expected result %h, actual %h", $time,
							want.message, want.residue, m_axis_tdata);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			residues_owed <= expected_residues.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam int RANDOM_PHASES   = 11;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int PRESSURE_PHASE  = 3;
	localparam int LONG_HOLD       = 8000;
	localparam int DRAIN_CYCLES    = 2300;
	localparam int QUIET_LIMIT     = 25000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
	localparam logic [W-1:0]         ALL_ONES     = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [W-1:0]         cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [W-1:0]         s_axis_tdata;  // message
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [W-1:0]         m_axis_tdata;  // result

	logic         steady;
	logic         hold_req;
	logic [W-1:0] key_modulus;
	int           mismatch_count;
	int           residues_owed;
	int           quiet_cycles;

	modular_exponentiation_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	power_mod_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.residues_owed  (residues_owed)
	);

	always #5 clk = ~clk;

	// leaves tvalid high on return so a back-to-back beat keeps it up
	task automatic offer_message(input logic [W-1:0] msg);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= msg;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (idx == REG_MODULUS) begin
			key_modulus = value;
		end
	endtask

	task automatic load_key(input logic [W-1:0] modulus, input logic [W-1:0] exponent);
		if ($urandom_range(0, 1)) begin
			write_key_reg(REG_MODULUS, modulus);
			write_key_reg(REG_EXPONENT, exponent);
		end else begin
			write_key_reg(REG_EXPONENT, exponent);
			write_key_reg(REG_MODULUS, modulus);
		end
		cfg_valid <= 1'b0;
	endtask

	// block must be idle before the key changes
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		wait (residues_owed == 0);
		@(negedge clk);
	endtask

	function automatic logic [W-1:0] pick_modulus();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return W'(1);
			2: return W'(2);
			3: return ALL_ONES;
			4, 5: return W'($urandom_range(2, 65535));
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-1:0] pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return W'(1);
			2: return ALL_ONES;
			3: return W'(65537);
			4: return W'($urandom_range(2, 15));
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-1:0] pick_message();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			2: return key_modulus - 1;
			3: return key_modulus + W'($urandom_range(0, 3));
			default: return W'($urandom);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		key_modulus = MODULUS_RST;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset key
		offer_message('0);
		offer_message(W'(1));
		offer_message(ALL_ONES);
		settle();

		// writes to unused indexes must leave the key alone
		write_key_reg(REG_SPARE_LO, W'($urandom));
		write_key_reg(REG_SPARE_HI, W'($urandom));
		cfg_valid <= 1'b0;
		offer_message(W'(5));
		settle();

		load_key(ALL_ONES, ALL_ONES);
		offer_message('0);
		offer_message(W'(1));
		offer_message(ALL_ONES - 1);
		offer_message(ALL_ONES);
		offer_message(W'($urandom));
		settle();

		// modulus of one, zero exponent
		load_key(W'(1), '0);
		offer_message('0);
		offer_message(ALL_ONES);
		settle();

		load_key('0, W'(5));
		offer_message(W'(7));
		offer_message(ALL_ONES);
		settle();

		load_key(32'hFFFF_FFFB, '0);
		offer_message('0);
		offer_message(W'(12345));
		offer_message(ALL_ONES);
		settle();

		// small textbook key pair, message at and above the modulus
		load_key(W'(3233), W'(17));
		offer_message(W'(65));
		offer_message(W'(3233));
		offer_message(W'(3300));
		settle();

		load_key(W'(3233), W'(2753));
		offer_message(W'(2790));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			load_key(pick_modulus(), pick_exponent());
			steady = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
			if (p == PRESSURE_PHASE) begin
				hold_req = 1'b1;
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				offer_message(pick_message());
			end
		end
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && residues_owed == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// result sink
	initial begin
		int gap;
		logic hold_done;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end
			gap = steady ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// watchdog on cycles with no beat on any channel
	initial begin
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Some tests failed");
		$finish;
	end

endmodule
